FILE: design/gcd_pkg.sv
// Shared constants and functions for the great-circle distance pipeline.
`timescale 1ns / 1ps
`default_nettype none
package gcd_pkg;

	localparam int unsigned ANGLE_FRACTION_BITS = 32;
	localparam int unsigned CORDIC_STAGES       = 32;
	// Datapath word: wide enough for gain-scaled Q(F) values plus sign and headroom.
	localparam int unsigned W                   = 64;
	localparam logic [63:0] PI_Q62              = 64'hC90FDAA22168C235;
	localparam logic [31:0] FULL_TURN_E7        = 32'd3600000000;
	localparam logic [31:0] HALF_TURN_E7        = 32'd1800000000;
	localparam logic [24:0] MAX_DISTANCE_M      = 25'd20015087;
	localparam logic [23:0] DIAMETER_M          = 24'd12742000;

	// Restoring long division, used only when building constant tables.
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [63:0] r;
		q = 64'd0;
		r = 64'd0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= den) begin
				r = r - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Arctangent of 2^-i in Q62, by the same truncated series as the checker's table.
	function automatic logic [63:0] atan_q62(input int unsigned i);
		logic [63:0] t;
		logic [63:0] n;
		logic [63:0] e;
		logic [63:0] term;
		t = 64'd0;
		if (i == 0) begin
			t = (PI_Q62 + 64'd2) >> 2;
		end else begin
			for (int k = 0; k < 64; k++) begin
				n = 64'(2 * k + 1);
				e = 64'(i) * n;
				if (e <= 64'd62) begin
					term = udiv64(64'd1 << (62 - e), n);
					if ((k & 1) == 0) t = t + term;
					else t = t - term;
				end
			end
		end
		return t;
	endfunction

	function automatic logic [63:0] q62_to_qf(input logic [63:0] v, input int unsigned f);
		return (v + (64'd1 << (61 - f))) >> (62 - f);
	endfunction

	function automatic logic [63:0] atan_qf(input int unsigned i, input int unsigned f);
		return q62_to_qf(atan_q62(i), f);
	endfunction

	// Arithmetic right shift of a signed word by a constant.
	function automatic logic signed [W-1:0] asr(input logic signed [W-1:0] v,
	                                            input int unsigned s);
		return v >>> s;
	endfunction

endpackage
`default_nettype wire

FILE: design/gcd_angle.sv
// Turns a full-angle difference in degrees*1e7 into a folded half angle in Q(F) radians.
`timescale 1ns / 1ps
`default_nettype none
module gcd_angle #(
	parameter int unsigned ANGLE_FRACTION_BITS = gcd_pkg::ANGLE_FRACTION_BITS
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    vld_in,
	input  wire logic signed [32:0]      diff,
	output logic                         vld_out,
	output logic [63:0]                  half
);
	// Stage 1: magnitude and fold to 0..half turn.
	logic [32:0] mag;
	logic [32:0] red;
	logic [31:0] fold_s1;
	logic        vld_s1;
	always_comb begin
		mag = diff[32] ? 33'(-diff) : 33'(diff);
		red = (mag >= {1'b0, gcd_pkg::FULL_TURN_E7}) ?
		      mag - {1'b0, gcd_pkg::FULL_TURN_E7} : mag;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
		end
	end
	always_ff @(posedge clk) begin
		fold_s1 <= (red[31:0] > gcd_pkg::HALF_TURN_E7) ?
		           gcd_pkg::FULL_TURN_E7 - red[31:0] : red[31:0];
	end

	// Stage 2 and 3: u*pi in two 32x32 partial products.
	logic [63:0] plo_s2, phi_s2;
	logic        vld_s2;
	logic [95:0] prod_s3;
	logic        vld_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end
	always_ff @(posedge clk) begin
		plo_s2  <= 64'(fold_s1) * 64'(gcd_pkg::PI_Q62[31:0]);
		phi_s2  <= 64'(fold_s1) * 64'(gcd_pkg::PI_Q62[63:32]);
		prod_s3 <= 96'(plo_s2) + {phi_s2, 32'd0};
	end

	// Division by 3.6e9 through a reciprocal product.
	// prod < 1.8e9*pi*2^62 so quotient < 2^63; reciprocal is 2^128/3.6e9 rounded.
	localparam int unsigned RecShift = 128;
	localparam logic [97:0] Recip =
		98'((128'd1 << 127) / 128'd3600000000 * 2 + 1);
	// Quotient estimate: q = (prod * Recip) >> RecShift, cut in 32-bit pieces over stages.
	logic [63:0] pp_s4 [0:2][0:3];
	logic        vld_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else vld_s4 <= vld_s3;
	end
	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			for (int b = 0; b < 4; b++) begin
				pp_s4[a][b] <= 64'(prod_s3[a*32 +: 32]) *
				               64'(32'(Recip >> (b*32)));
			end
		end
	end
	// Sum each row of partial products, one row per 32-bit slice of prod.
	logic [129:0] row [0:2];
	logic [129:0] row_s5 [0:2];
	logic         vld_s5;
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			row[a] = '0;
			for (int b = 0; b < 4; b++)
				row[a] = row[a] + (130'(pp_s4[a][b]) << (b * 32));
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else vld_s5 <= vld_s4;
	end
	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++)
			row_s5[a] <= row[a];
	end
	logic [195:0] acc;
	always_comb begin
		acc = 196'(row_s5[0]) + (196'(row_s5[1]) << 32) + (196'(row_s5[2]) << 64);
	end
	// The estimate is low by one only for an exact quotient, and then the fraction
	// sits within 2^-33 of one: its top 33 bits are all set only in that case.
	logic [63:0] qest_s6;
	logic        frac_s6;
	logic        vld_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else vld_s6 <= vld_s5;
	end
	always_ff @(posedge clk) begin
		qest_s6 <= 64'(acc >> RecShift);
		frac_s6 <= &acc[RecShift-1 -: 33];
	end
	logic [63:0] q;
	always_comb begin
		q = qest_s6 + 64'(frac_s6);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_out <= 1'b0;
		else vld_out <= vld_s6;
	end
	always_ff @(posedge clk) begin
		half <= gcd_pkg::q62_to_qf(q, ANGLE_FRACTION_BITS);
	end
endmodule
`default_nettype wire

FILE: design/gcd_cordic.sv
// Pipelined CORDIC, one stage per iteration, in rotation or vectoring mode.
`timescale 1ns / 1ps
`default_nettype none
module gcd_cordic #(
	parameter int unsigned ANGLE_FRACTION_BITS = gcd_pkg::ANGLE_FRACTION_BITS,
	parameter int unsigned CORDIC_STAGES       = gcd_pkg::CORDIC_STAGES,
	parameter bit          VECTORING           = 1'b0
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           vld_in,
	input  wire logic signed [gcd_pkg::W-1:0]   x_in,
	input  wire logic signed [gcd_pkg::W-1:0]   y_in,
	input  wire logic signed [gcd_pkg::W-1:0]   z_in,
	output logic                                vld_out,
	output logic signed [gcd_pkg::W-1:0]        x_out,
	output logic signed [gcd_pkg::W-1:0]        y_out,
	output logic signed [gcd_pkg::W-1:0]        z_out
);
	localparam int unsigned W = gcd_pkg::W;
	logic signed [W-1:0] x_s [0:CORDIC_STAGES];
	logic signed [W-1:0] y_s [0:CORDIC_STAGES];
	logic signed [W-1:0] z_s [0:CORDIC_STAGES];
	logic                v_s [0:CORDIC_STAGES];

	assign x_s[0] = x_in;
	assign y_s[0] = y_in;
	assign z_s[0] = z_in;
	assign v_s[0] = vld_in;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		localparam logic signed [W-1:0] Atan =
			W'(gcd_pkg::atan_qf(i, ANGLE_FRACTION_BITS));
		logic dir;
		assign dir = VECTORING ? !y_s[i][W-1] : !z_s[i][W-1];
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[i+1] <= 1'b0;
			else v_s[i+1] <= v_s[i];
		end
		always_ff @(posedge clk) begin
			if (dir == !VECTORING) begin
				x_s[i+1] <= x_s[i] - gcd_pkg::asr(y_s[i], i);
				y_s[i+1] <= y_s[i] + gcd_pkg::asr(x_s[i], i);
			end else begin
				x_s[i+1] <= x_s[i] + gcd_pkg::asr(y_s[i], i);
				y_s[i+1] <= y_s[i] - gcd_pkg::asr(x_s[i], i);
			end
			z_s[i+1] <= (dir ^ VECTORING) ? z_s[i] - Atan : z_s[i] + Atan;
		end
	end

	assign vld_out = v_s[CORDIC_STAGES];
	assign x_out   = x_s[CORDIC_STAGES];
	assign y_out   = y_s[CORDIC_STAGES];
	assign z_out   = z_s[CORDIC_STAGES];
endmodule
`default_nettype wire

FILE: design/gcd_mul.sv
// Unsigned product of two Q(F) words rounded half up back to Q(F), over two stages.
`timescale 1ns / 1ps
`default_nettype none
module gcd_mul #(
	parameter int unsigned ANGLE_FRACTION_BITS = gcd_pkg::ANGLE_FRACTION_BITS
) (
	input  wire logic        clk,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	output logic      [63:0] p
);
	// Operands stay below 2^(F+2), so their top halves are narrow.
	logic [63:0] ll_s1, lh_s1, hl_s1, hh_s1;
	always_ff @(posedge clk) begin
		ll_s1 <= 64'(a[31:0])  * 64'(b[31:0]);
		lh_s1 <= 64'(a[31:0])  * 64'(b[63:32]);
		hl_s1 <= 64'(a[63:32]) * 64'(b[31:0]);
		hh_s1 <= 64'(a[63:32]) * 64'(b[63:32]);
	end
	logic [127:0] full;
	always_comb begin
		full = 128'(ll_s1) + (128'(lh_s1) << 32) + (128'(hl_s1) << 32) +
		       (128'(hh_s1) << 64) + (128'd1 << (ANGLE_FRACTION_BITS - 1));
	end
	always_ff @(posedge clk) begin
		p <= 64'(full >> ANGLE_FRACTION_BITS);
	end
endmodule
`default_nettype wire

FILE: design/great_circle_distance.sv
// Top level: haversine great-circle distance between two positions.
// One position pair is taken each cycle (busy stays low) and its distance appears
// on distance_metres with valid high exactly one cycle, after angle scaling,
// CORDIC rotation, the multiplies, two chained vectoring passes and the scaling
// and saturation registers. Results cannot be held off by the receiver.
`timescale 1ns / 1ps
`default_nettype none
module great_circle_distance #(
	parameter int unsigned ANGLE_FRACTION_BITS = gcd_pkg::ANGLE_FRACTION_BITS,
	parameter int unsigned CORDIC_STAGES       = gcd_pkg::CORDIC_STAGES
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [30:0] first_latitude,
	input  wire logic signed [31:0] first_longitude,
	input  wire logic signed [30:0] second_latitude,
	input  wire logic signed [31:0] second_longitude,
	output logic                    valid,
	output logic [24:0]             distance_metres
);
	localparam int unsigned W = gcd_pkg::W;
	assign busy = 1'b0;

	logic signed [32:0] dlat, slat, dlon;
	assign dlat = 33'(second_latitude) - 33'(first_latitude);
	assign slat = 33'(second_latitude) + 33'(first_latitude);
	assign dlon = 33'(second_longitude) - 33'(first_longitude);

	logic        hv_d, hv_s, hv_l;
	logic [63:0] h_d, h_s, h_l;
	gcd_angle #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_ang_d (
		.clk, .arst_n, .vld_in(start), .diff(dlat), .vld_out(hv_d), .half(h_d));
	gcd_angle #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_ang_s (
		.clk, .arst_n, .vld_in(start), .diff(slat), .vld_out(hv_s), .half(h_s));
	gcd_angle #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_ang_l (
		.clk, .arst_n, .vld_in(start), .diff(dlon), .vld_out(hv_l), .half(h_l));

	localparam logic signed [W-1:0] One = W'(64'd1 << ANGLE_FRACTION_BITS);
	logic rv;
	logic signed [W-1:0] xd, yd, xs, ys, xl, yl;
	gcd_cordic #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS),
	             .CORDIC_STAGES(CORDIC_STAGES), .VECTORING(1'b0)) u_rot_d (
		.clk, .arst_n, .vld_in(hv_d), .x_in(One), .y_in('0), .z_in(W'(h_d)),
		.vld_out(rv), .x_out(xd), .y_out(yd), .z_out());
	gcd_cordic #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS),
	             .CORDIC_STAGES(CORDIC_STAGES), .VECTORING(1'b0)) u_rot_s (
		.clk, .arst_n, .vld_in(hv_s), .x_in(One), .y_in('0), .z_in(W'(h_s)),
		.vld_out(), .x_out(xs), .y_out(ys), .z_out());
	gcd_cordic #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS),
	             .CORDIC_STAGES(CORDIC_STAGES), .VECTORING(1'b0)) u_rot_l (
		.clk, .arst_n, .vld_in(hv_l), .x_in(One), .y_in('0), .z_in(W'(h_l)),
		.vld_out(), .x_out(xl), .y_out(yl), .z_out());

	logic [63:0] cd, sd, cs, ss, cl, sl;
	assign cd = xd[W-1] ? 64'(-xd) : 64'(xd);
	assign sd = yd[W-1] ? 64'(-yd) : 64'(yd);
	assign cs = xs[W-1] ? 64'(-xs) : 64'(xs);
	assign ss = ys[W-1] ? 64'(-ys) : 64'(ys);
	assign cl = xl[W-1] ? 64'(-xl) : 64'(xl);
	assign sl = yl[W-1] ? 64'(-yl) : 64'(yl);

	logic [63:0] p_sdcl, p_cssl, p_cdcl, p_sssl;
	gcd_mul #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_m0 (
		.clk, .a(sd), .b(cl), .p(p_sdcl));
	gcd_mul #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_m1 (
		.clk, .a(cs), .b(sl), .p(p_cssl));
	gcd_mul #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_m2 (
		.clk, .a(cd), .b(cl), .p(p_cdcl));
	gcd_mul #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_m3 (
		.clk, .a(ss), .b(sl), .p(p_sssl));
	logic mv_s1, mv_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_s1 <= 1'b0;
			mv_s2 <= 1'b0;
		end else begin
			mv_s1 <= rv;
			mv_s2 <= mv_s1;
		end
	end

	logic va;
	logic signed [W-1:0] ma, mb;
	gcd_cordic #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS),
	             .CORDIC_STAGES(CORDIC_STAGES), .VECTORING(1'b1)) u_vec_a (
		.clk, .arst_n, .vld_in(mv_s2), .x_in(W'(p_sdcl)), .y_in(W'(p_cssl)), .z_in('0),
		.vld_out(va), .x_out(ma), .y_out(), .z_out());
	gcd_cordic #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS),
	             .CORDIC_STAGES(CORDIC_STAGES), .VECTORING(1'b1)) u_vec_b (
		.clk, .arst_n, .vld_in(mv_s2), .x_in(W'(p_cdcl)), .y_in(W'(p_sssl)), .z_in('0),
		.vld_out(), .x_out(mb), .y_out(), .z_out());

	logic signed [W-1:0] ma_c, mb_c;
	assign ma_c = ma[W-1] ? '0 : ma;
	assign mb_c = mb[W-1] ? '0 : mb;

	logic vc;
	logic signed [W-1:0] ang;
	gcd_cordic #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS),
	             .CORDIC_STAGES(CORDIC_STAGES), .VECTORING(1'b1)) u_vec_c (
		.clk, .arst_n, .vld_in(va), .x_in(mb_c), .y_in(ma_c), .z_in('0),
		.vld_out(vc), .x_out(), .y_out(), .z_out(ang));

	// Scale the half central angle by the diameter and round; clamp negatives to zero and saturate at MAX_DISTANCE_M.
	logic [63:0] ang_u;
	assign ang_u = ang[W-1] ? 64'd0 : 64'(ang);
	logic [63:0] dl_s1, dh_s1;
	logic        dv_s1, dv_s2;
	logic [63:0] dist_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s1 <= 1'b0;
			dv_s2 <= 1'b0;
			valid <= 1'b0;
		end else begin
			dv_s1 <= vc;
			dv_s2 <= dv_s1;
			valid <= dv_s2;
		end
	end
	logic [95:0] dfull;
	always_comb begin
		dfull = 96'(dl_s1) + (96'(dh_s1) << 32) +
		        (96'd1 << (ANGLE_FRACTION_BITS - 1));
	end
	always_ff @(posedge clk) begin
		dl_s1   <= 64'(ang_u[31:0])  * 64'(gcd_pkg::DIAMETER_M);
		dh_s1   <= 64'(ang_u[63:32]) * 64'(gcd_pkg::DIAMETER_M);
		dist_s2 <= 64'(dfull >> ANGLE_FRACTION_BITS);
		distance_metres <= (dist_s2 > 64'(gcd_pkg::MAX_DISTANCE_M)) ?
		                   gcd_pkg::MAX_DISTANCE_M : dist_s2[24:0];
	end
endmodule
`default_nettype wire

FILE: test/great_circle_distance_checker.sv
// Checker for the great-circle distance block: predicts each distance and compares results.
`timescale 1ns / 1ps
module great_circle_distance_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               busy,
	input  wire logic signed [30:0] first_latitude,
	input  wire logic signed [31:0] first_longitude,
	input  wire logic signed [30:0] second_latitude,
	input  wire logic signed [31:0] second_longitude,
	input  wire logic               valid,
	input  wire logic [24:0]        distance_metres,
	output int                      fail_count,
	output int                      pending
);
	localparam int unsigned F = gcd_pkg::ANGLE_FRACTION_BITS;
	localparam int unsigned N = gcd_pkg::CORDIC_STAGES;
	localparam longint unsigned TURN = 64'd3600000000;
	localparam longint unsigned HALF = 64'd1800000000;

	longint signed arctan_table[N];
	logic [24:0] distance_queue[$];
	int mismatches;

	function automatic longint unsigned round_to_qf(longint unsigned v);
		return (v + (64'd1 << (61 - F))) >> (62 - F);
	endfunction

	function automatic longint unsigned fixed_product(longint unsigned a, longint unsigned b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p + (128'd1 << (F - 1));
		return p[F +: 64];
	endfunction

	// Fold a full-angle difference and halve it into Q(F) radians.
	function automatic longint signed half_radians(longint signed d);
		longint unsigned u;
		logic [127:0] p;
		logic [127:0] q;
		u = d < 0 ? 64'd0 - 64'(d) : 64'(d);
		while (u >= TURN) u -= TURN;
		if (u > HALF) u = TURN - u;
		p = {64'd0, u} * {64'd0, gcd_pkg::PI_Q62};
		q = p / {64'd0, TURN};
		return longint'(round_to_qf(q[63:0]));
	endfunction

	function automatic void sin_cos(input longint signed h, output longint unsigned c,
	                                output longint unsigned s);
		longint signed x, y, z, dx, dy;
		x = 64'sd1 <<< F;
		y = 0;
		z = h;
		for (int i = 0; i < N; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= arctan_table[i];
			end else begin
				x += dx; y -= dy; z += arctan_table[i];
			end
		end
		c = x < 0 ? 64'(-x) : 64'(x);
		s = y < 0 ? 64'(-y) : 64'(y);
	endfunction

	function automatic void magnitude_angle(input longint unsigned xin,
	                                        input longint unsigned yin,
	                                        output longint signed mag,
	                                        output longint signed ang);
		longint signed x, y, z, dx, dy;
		x = longint'(xin);
		y = longint'(yin);
		z = 0;
		for (int i = 0; i < N; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += arctan_table[i];
			end else begin
				x -= dx; y += dy; z -= arctan_table[i];
			end
		end
		ang = z;
		mag = x < 0 ? 0 : x;
	endfunction

	function automatic logic [24:0] predict_distance(longint signed lat1, longint signed lon1,
	                                                 longint signed lat2, longint signed lon2);
		longint unsigned cd, sd, cs, ss, cl, sl, metres;
		longint signed ma, mb, ang;
		sin_cos(half_radians(lat2 - lat1), cd, sd);
		sin_cos(half_radians(lat1 + lat2), cs, ss);
		sin_cos(half_radians(lon2 - lon1), cl, sl);
		magnitude_angle(fixed_product(sd, cl), fixed_product(cs, sl), ma, ang);
		magnitude_angle(fixed_product(cd, cl), fixed_product(ss, sl), mb, ang);
		magnitude_angle(64'(mb), 64'(ma), ma, ang);
		if (ang < 0) ang = 0;
		metres = fixed_product(64'(ang), 64'd12742000);
		if (metres > 64'(gcd_pkg::MAX_DISTANCE_M)) metres = 64'(gcd_pkg::MAX_DISTANCE_M);
		return metres[24:0];
	endfunction

	initial begin
		longint unsigned t, n, term;
		for (int i = 0; i < N; i++) begin
			t = 0;
			if (i == 0) begin
				t = (gcd_pkg::PI_Q62 + 64'd2) >> 2;
			end else begin
				for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
					n = 2 * k + 1;
					term = (64'd1 << (62 - i * n)) / n;
					if (k % 2 == 0) t += term;
					else t -= term;
				end
			end
			arctan_table[i] = longint'(round_to_qf(t));
		end
	end

	always @(posedge clk) begin
		logic [24:0] want;
		if (arst_n) begin
			if (valid) begin
				if (distance_queue.size() == 0) begin
					fail_count++;
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word: distance_metres=%0d", distance_metres);
				end else begin
					want = distance_queue.pop_front();
					if (want !== distance_metres) begin
						fail_count++;
						mismatches++;
						if (mismatches <= 10)
							$display("distance_metres mismatch: expected %0d, actual %0d",
							         want, distance_metres);
					end
				end
			end
			if (start && !busy)
				distance_queue.push_back(predict_distance(longint'(first_latitude),
					longint'(first_longitude), longint'(second_latitude),
					longint'(second_longitude)));
			pending <= distance_queue.size();
		end
	end
endmodule

FILE: test/great_circle_distance_test.sv
// Testbench top: drives position pairs into the distance block and reports the verdict.
`timescale 1ns / 1ps
module great_circle_distance_test;
	localparam int RANDOM_WORDS = 1500;
	localparam int LATENCY = 7 + 32 + 2 + 64 + 3;
	localparam longint CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [30:0] first_latitude = '0;
	logic signed [31:0] first_longitude = '0;
	logic signed [30:0] second_latitude = '0;
	logic signed [31:0] second_longitude = '0;
	logic valid;
	logic [24:0] distance_metres;
	int fail_count;
	int pending;
	longint cycles = 0;

	great_circle_distance dut (.*);

	great_circle_distance_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic int rand_lat();
		return int'($urandom_range(1800000000, 0)) - 900000000;
	endfunction

	function automatic int rand_lon();
		return int'($urandom_range(3600000000, 0) - 64'd1800000000);
	endfunction

	task automatic idle_gap();
		int r;
		int len;
		r = $urandom_range(99, 0);
		len = r < 70 ? 0 : (r < 95 ? $urandom_range(4, 1) : $urandom_range(200, 20));
		if (len > 0) begin
			start <= 1'b0;
			repeat (len) @(negedge clk);
		end
	endtask

	// Present one word and hold it until the block takes it.
	task automatic send_word(input int lat1, input int lon1, input int lat2, input int lon2);
		start <= 1'b1;
		first_latitude <= lat1[30:0];
		first_longitude <= lon1;
		second_latitude <= lat2[30:0];
		second_longitude <= lon2;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	initial begin
		int lat1, lon1, lat2, lon2, mode, burst;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_word(0, 0, 0, 0);
		send_word(900000000, 1800000000, 900000000, 1800000000);
		send_word(900000000, 0, -900000000, 0);
		send_word(0, 0, 0, 1800000000);
		send_word(0, -1800000000, 0, 1800000000);
		send_word(-900000000, -1800000000, 900000000, 1800000000);
		send_word(450000000, 100000000, -450000000, -1700000000);
		send_word(0, 0, 1, 0);
		send_word(0, 0, 0, 1);
		send_word(-1073741824, 32'sh80000000, 1073741823, 32'sh7FFFFFFF);
		send_word(1073741823, 32'sh7FFFFFFF, -1073741824, 32'sh80000000);
		send_word(-1, -1, -1, -1);
		send_word(-1, 0, 0, -1);
		send_word(519000000, -1000000, 408000000, -740000000);
		send_word(123456789, 987654321, 123456789, 987654321);
		send_word(899999999, 0, 899999999, 1800000000);
		send_word(0, 900000000, 0, -900000000);
		idle_gap();

		burst = 0;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			mode = $urandom_range(99, 0);
			lat1 = rand_lat();
			lon1 = rand_lon();
			if (mode < 10) begin
				lat1 = $urandom;
				lon1 = $urandom;
				lat2 = $urandom;
				lon2 = $urandom;
			end else if (mode < 40) begin
				lat2 = lat1 + int'($urandom_range(2000000, 0)) - 1000000;
				lon2 = lon1 + int'($urandom_range(2000000, 0)) - 1000000;
			end else if (mode < 50) begin
				lat2 = -lat1 + int'($urandom_range(2000, 0)) - 1000;
				lon2 = lon1 >= 0 ? lon1 - 1800000000 : lon1 + 1800000000;
			end else begin
				lat2 = rand_lat();
				lon2 = rand_lon();
			end
			send_word(lat1, lon1, lat2, lon2);
			if (n == RANDOM_WORDS / 2) begin
				start <= 1'b0;
				@(negedge clk);
				while (pending != 0) @(negedge clk);
			end
			// Alternate stretches with gaps and back-to-back stretches.
			if (burst > 0) burst--;
			else if ($urandom_range(19, 0) == 0) burst = $urandom_range(60, 10);
			else idle_gap();
		end
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule

FILE: files.f
design/gcd_pkg.sv
design/gcd_angle.sv
design/gcd_cordic.sv
design/gcd_mul.sv
design/great_circle_distance.sv
test/great_circle_distance_checker.sv
test/great_circle_distance_test.sv
